>>> hw/rtl/scpk_pkg.sv
// Shared types and constants for the SPH contact pair kernel.
`default_nettype none
package scpk_pkg;

    // Diameter after reset, Q8.8 pixels, and its square
    localparam logic [15:0] DIAM_RESET = 16'd512;
    localparam logic [31:0] D2_RESET   = 32'(32'd512 * 32'd512);

    // Bits resolved by the root search, one per back-end step
    localparam int unsigned STEPS       = 16;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam logic [15:0] NORM_MAX    = 16'd32767;

    // Word handed from the front end to the back end through the queue
    typedef struct packed {
        logic        hit;
        logic [11:0] a_index;
        logic [11:0] b_index;
        logic [31:0] dsq;
        logic [15:0] adx;
        logic [15:0] ady;
        logic        neg_x;
        logic        neg_y;
    } t_pair_entry;

    // One stage of the back-end root search
    typedef struct packed {
        t_pair_entry ent;
        logic [31:0] cx2;
        logic [31:0] cy2;
        logic [63:0] w_s;   // (r*d)^2
        logic [47:0] w_t;   // r*d^2
        logic [15:0] w_r;
        logic [63:0] x_u;   // m^2*dsq
        logic [47:0] x_v;   // m*dsq
        logic [15:0] x_m;
        logic [63:0] y_u;
        logic [47:0] y_v;
        logic [15:0] y_m;
    } t_iter;

endpackage
`default_nettype wire

>>> hw/rtl/scpk_ifs.sv
// Handshake interfaces: pair input, contact output and configuration write.
`default_nettype none
interface scpk_pair_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] a_x;
    logic signed [23:0] a_y;
    logic signed [23:0] b_x;
    logic signed [23:0] b_y;
    logic               a_dead;
    logic               b_dead;
    logic [11:0]        a_index;
    logic [11:0]        b_index;

    modport source (output valid, a_x, a_y, b_x, b_y, a_dead, b_dead, a_index, b_index,
                    input ready);
    modport sink   (input valid, a_x, a_y, b_x, b_y, a_dead, b_dead, a_index, b_index,
                    output ready);
endinterface

interface scpk_contact_if;
    logic               valid;
    logic               ready;
    logic               contact_hit;
    logic [11:0]        first_index;
    logic [11:0]        second_index;
    logic [15:0]        weight;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;

    modport source (output valid, contact_hit, first_index, second_index, weight,
                    normal_x, normal_y, input ready);
    modport sink   (input valid, contact_hit, first_index, second_index, weight,
                    normal_x, normal_y, output ready);
endinterface

interface scpk_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/scpk_front.sv
// Front end: diameter register, pair differences, squares and contact test.
`default_nettype none
module scpk_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    scpk_pair_if.sink                 i_pair,
    scpk_cfg_if.sink                  i_cfg,
    input  wire logic                 i_q_full,
    output logic                      o_push,
    output scpk_pkg::t_pair_entry     o_push_data,
    output logic [31:0]               o_d2
);

    logic        r_d2_vld;
    logic [31:0] r_d2;

    logic        fe;
    logic signed [24:0] dx, dy;

    logic        r_s1_vld, r_s2_vld;
    logic [24:0] r_adx, r_ady;
    logic        r_s1_negx, r_s1_negy, r_s1_dead;
    logic [11:0] r_s1_ai, r_s1_bi;

    logic [48:0] r_sqx, r_sqy;
    logic [15:0] r_s2_adx, r_s2_ady;
    logic        r_s2_negx, r_s2_negy, r_s2_dead;
    logic [11:0] r_s2_ai, r_s2_bi;

    logic [49:0] dsq;

    // Diameter squared, refreshed on each config write
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d2     <= scpk_pkg::D2_RESET;
            r_d2_vld <= 1'b0;
        end else begin
            r_d2_vld <= 1'b1;
            if (i_cfg.valid) begin
                r_d2 <= 32'(i_cfg.data) * 32'(i_cfg.data);
            end
        end
    end
    assign o_d2 = r_d2;

    // Whole front advances unless the last stage is blocked by a full queue
    assign fe           = !r_s2_vld || !i_q_full;
    assign i_pair.ready = fe && r_d2_vld;

    assign dx = {i_pair.b_x[23], i_pair.b_x} - {i_pair.a_x[23], i_pair.a_x};
    assign dy = {i_pair.b_y[23], i_pair.b_y} - {i_pair.a_y[23], i_pair.a_y};

    // Stage 1: differences and magnitudes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (fe) begin
            r_s1_vld <= i_pair.valid && r_d2_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (fe) begin
            r_adx     <= dx[24] ? 25'(-dx) : 25'(dx);
            r_ady     <= dy[24] ? 25'(-dy) : 25'(dy);
            r_s1_negx <= dx[24];
            r_s1_negy <= dy[24];
            r_s1_dead <= i_pair.a_dead | i_pair.b_dead;
            r_s1_ai   <= i_pair.a_index;
            r_s1_bi   <= i_pair.b_index;
        end
    end

    // Stage 2: squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (fe) begin
            r_s2_vld <= r_s1_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (fe) begin
            r_sqx     <= 49'(50'(r_adx) * 50'(r_adx));
            r_sqy     <= 49'(50'(r_ady) * 50'(r_ady));
            r_s2_adx  <= r_adx[15:0];
            r_s2_ady  <= r_ady[15:0];
            r_s2_negx <= r_s1_negx;
            r_s2_negy <= r_s1_negy;
            r_s2_dead <= r_s1_dead;
            r_s2_ai   <= r_s1_ai;
            r_s2_bi   <= r_s1_bi;
        end
    end

    // Distance squared and the contact test, straight into the queue
    assign dsq    = 50'(r_sqx) + 50'(r_sqy);
    assign o_push = r_s2_vld && !i_q_full;
    always_comb begin
        o_push_data.hit     = !r_s2_dead && (dsq != 50'd0) && (dsq < 50'(r_d2));
        o_push_data.a_index = r_s2_ai;
        o_push_data.b_index = r_s2_bi;
        o_push_data.dsq     = dsq[31:0];
        o_push_data.adx     = r_s2_adx;
        o_push_data.ady     = r_s2_ady;
        o_push_data.neg_x   = r_s2_negx;
        o_push_data.neg_y   = r_s2_negy;
    end

endmodule
`default_nettype wire

>>> hw/rtl/scpk_queue.sv
// Small FIFO between the front end and the back end.
`default_nettype none
module scpk_queue #(
    parameter int unsigned DEPTH = scpk_pkg::QUEUE_DEPTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  scpk_pkg::t_pair_entry     i_push_data,
    output logic                      o_full,
    input  wire logic                 i_pop,
    output scpk_pkg::t_pair_entry     o_pop_data,
    output logic                      o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    scpk_pkg::t_pair_entry r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full     = (r_cnt == CNT_FULL);
    assign o_empty    = (r_cnt == '0);
    assign o_pop_data = r_mem[r_rd];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/scpk_back.sv
// Back end: pipelined bit-by-bit root search for weight and unit normal.
`default_nettype none
module scpk_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_empty,
    input  scpk_pkg::t_pair_entry     i_q_data,
    output logic                      o_pop,
    input  wire logic [31:0]          i_d2,
    scpk_contact_if.source            o_contact
);

    localparam int unsigned N = scpk_pkg::STEPS;

    scpk_pkg::t_iter r_st  [N+1];
    logic            r_vld [N+1];
    scpk_pkg::t_iter n_st  [N+1];

    logic               be;
    logic               r_out_vld;
    logic               r_hit;
    logic [11:0]        r_ai, r_bi;
    logic [15:0]        r_w;
    logic signed [15:0] r_nx, r_ny;
    logic [15:0]        mag_x, mag_y;

    // Whole back end moves unless a finished word waits at the output
    assign be    = !r_out_vld || o_contact.ready;
    assign o_pop = be && !i_q_empty;

    // Stage 0: component squares
    always_comb begin
        n_st[0]     = '0;
        n_st[0].ent = i_q_data;
        n_st[0].cx2 = 32'(i_q_data.adx) * 32'(i_q_data.adx);
        n_st[0].cy2 = 32'(i_q_data.ady) * 32'(i_q_data.ady);
    end

    // One result bit of each search per stage, most significant first
    for (genvar g = 0; g < N; g++) begin : g_step
        localparam int K = N - 1 - g;
        logic [63:0] ws_c, xu_c, yu_c;
        always_comb begin
            ws_c = r_st[g].w_s + (64'(r_st[g].w_t) << (K + 1)) + (64'(i_d2) << (2 * K));
            xu_c = r_st[g].x_u + (64'(r_st[g].x_v) << (K + 1))
                 + (64'(r_st[g].ent.dsq) << (2 * K));
            yu_c = r_st[g].y_u + (64'(r_st[g].y_v) << (K + 1))
                 + (64'(r_st[g].ent.dsq) << (2 * K));
            n_st[g+1] = r_st[g];
            // largest r with (r*d)^2 < dsq*2^32
            if (ws_c < {r_st[g].ent.dsq, 32'd0}) begin
                n_st[g+1].w_s    = ws_c;
                n_st[g+1].w_t    = r_st[g].w_t + (48'(i_d2) << K);
                n_st[g+1].w_r[K] = 1'b1;
            end
            // largest m with m^2*dsq <= cx^2*2^30
            if (xu_c <= {2'b00, r_st[g].cx2, 30'd0}) begin
                n_st[g+1].x_u    = xu_c;
                n_st[g+1].x_v    = r_st[g].x_v + (48'(r_st[g].ent.dsq) << K);
                n_st[g+1].x_m[K] = 1'b1;
            end
            if (yu_c <= {2'b00, r_st[g].cy2, 30'd0}) begin
                n_st[g+1].y_u    = yu_c;
                n_st[g+1].y_v    = r_st[g].y_v + (48'(r_st[g].ent.dsq) << K);
                n_st[g+1].y_m[K] = 1'b1;
            end
        end
    end

    // Stage registers
    for (genvar s = 0; s <= N; s++) begin : g_reg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (be) begin
                r_vld[s] <= (s == 0) ? o_pop : r_vld[(s == 0) ? 0 : s - 1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (be) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    // Output formatting: weight = 65535 - r, saturated signed normal, all zero on a miss
    assign mag_x = (r_st[N].x_m > scpk_pkg::NORM_MAX) ? scpk_pkg::NORM_MAX : r_st[N].x_m;
    assign mag_y = (r_st[N].y_m > scpk_pkg::NORM_MAX) ? scpk_pkg::NORM_MAX : r_st[N].y_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (be) begin
            r_out_vld <= r_vld[N];
        end
    end
    always_ff @(posedge i_clk) begin
        if (be) begin
            r_hit <= r_st[N].ent.hit;
            r_ai  <= r_st[N].ent.a_index;
            r_bi  <= r_st[N].ent.b_index;
            if (r_st[N].ent.hit) begin
                r_w  <= ~r_st[N].w_r;
                r_nx <= r_st[N].ent.neg_x ? -$signed(mag_x) : $signed(mag_x);
                r_ny <= r_st[N].ent.neg_y ? -$signed(mag_y) : $signed(mag_y);
            end else begin
                r_w  <= '0;
                r_nx <= '0;
                r_ny <= '0;
            end
        end
    end

    assign o_contact.valid        = r_out_vld;
    assign o_contact.contact_hit  = r_hit;
    assign o_contact.first_index  = r_ai;
    assign o_contact.second_index = r_bi;
    assign o_contact.weight       = r_w;
    assign o_contact.normal_x     = r_nx;
    assign o_contact.normal_y     = r_ny;

endmodule
`default_nettype wire

>>> hw/rtl/sph_contact_pair_kernel.sv
// Top level of the SPH contact pair kernel.
// Takes one candidate pair per clock unless a full queue or a stalled output holds
// it back, and returns one word per pair: contact flag, both indices, weight
// 1 - dist/diameter in Q0.16 and the A-to-B unit normal in Q1.15. A pair passes
// two front stages, one queue slot, a square stage, sixteen search stages and the
// output register; most are the sixteen-step root search, one result bit per stage.
// A short queue lets the input flow on while the output stalls, until its
// QUEUE_DEPTH entries fill. The user must write the diameter through the config
// channel only while the block is idle, which it does not enforce; reset 2.0 px.
`default_nettype none
module sph_contact_pair_kernel #(
    parameter int unsigned QUEUE_DEPTH = scpk_pkg::QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    scpk_pair_if.sink       i_pair,
    scpk_cfg_if.sink        i_cfg,
    scpk_contact_if.source  o_contact
);

    logic                  push, pop, q_full, q_empty;
    scpk_pkg::t_pair_entry push_data, pop_data;
    logic [31:0]           d2;

    scpk_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pair      (i_pair),
        .i_cfg       (i_cfg),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_data (push_data),
        .o_d2        (d2)
    );

    scpk_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_empty     (q_empty)
    );

    scpk_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (pop_data),
        .o_pop     (pop),
        .i_d2      (d2),
        .o_contact (o_contact)
    );

endmodule
`default_nettype wire

>>> hw/rtl/scpk_checker.sv
// Port-level checks for the contact kernel and their bind to the top level.
`default_nettype none
module scpk_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        i_ready,
    input wire logic        i_hit,
    input wire logic [15:0] i_weight,
    input wire logic [15:0] i_nx,
    input wire logic [15:0] i_ny
);

    // Valid, hit flag, weight and normal hold while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_weight) && $stable(i_nx)
        && $stable(i_ny) && $stable(i_hit))
        else $error("output word changed while stalled");

    // No contact means zero weight and normal
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_hit |-> i_weight == 16'd0 && i_nx == 16'd0 && i_ny == 16'd0)
        else $error("nonzero fields on a miss");

    // Normal components never reach the negative full scale
    a_norm_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_nx != 16'h8000 && i_ny != 16'h8000)
        else $error("normal not saturated");

    // Nothing comes out right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("output valid after reset");

endmodule

bind sph_contact_pair_kernel scpk_checker u_scpk_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_contact.valid),
    .i_ready  (o_contact.ready),
    .i_hit    (o_contact.contact_hit),
    .i_weight (o_contact.weight),
    .i_nx     (o_contact.normal_x),
    .i_ny     (o_contact.normal_y)
);
`default_nettype wire
